@@ hdl/rmwf_pkg.sv @@
`default_nettype none
package rmwf_pkg;

  localparam int DEF_MAX_KERNEL = 15;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int HEIGHT_LIMIT   = 4096;

  localparam int KSIZE_W = 4;
  localparam int WIDTH_W = 12;
  localparam int HGT_W   = 13;
  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 2;
  localparam int KEFF_W  = 5;
  localparam int CRD_W   = 15;
  localparam int CHAN_W  = 8;
  localparam int NCHAN   = 3;
  localparam int PIX_W   = CHAN_W * NCHAN;
  localparam int OCOL_W  = 11;
  localparam int OROW_W  = 12;
  localparam int OUT_DATA_W = 48;

  localparam logic [CIDX_W-1:0] REG_KERNEL = 2'd0;
  localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic accept;
    logic eval;
    logic setup;
    logic issue;
    logic decide;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_res;
    logic last_issue;
    logic last_bit;
    logic last_x;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

@@ hdl/rgb_median_window_filter_top.sv @@
`default_nettype none
// An item with no result returns to idle after evaluate. Otherwise each result runs setup,
//   then per bit: issue (one window sample read per cycle), drain, decide; then emit.
// Sequential: no new item is taken until the item's last result is emitted, and a result
//   stalls in emit while the previous one waits for out_tready.
// Reset (rst_n low, synchronous): kernel 3, width 640, height 480, position at
//   frame start, no result pending. Line store is not cleared; only written entries are read.
module rgb_median_window_filter_top #(
  parameter int MAX_KERNEL = rmwf_pkg::DEF_MAX_KERNEL,
  parameter int MAX_WIDTH  = rmwf_pkg::DEF_MAX_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // red_in, green_in, blue_in
  input  wire logic        in_tuser,   // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [rmwf_pkg::OUT_DATA_W-1:0] out_tdata, // red, green, blue, column, row, 0
  output logic             out_tlast,  // last_in_run
  output logic             out_tuser,  // frame_done
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [rmwf_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [rmwf_pkg::CFG_W-1:0]  cfg_data
);
  import rmwf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;
  logic [PIX_W-1:0]  res_pix;
  logic [OCOL_W-1:0] res_col;
  logic [OROW_W-1:0] res_row;

  // Controller: sequences evaluate, per-bit window scans, and result hand-off.
  rmwf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .cfg_valid(cfg_valid),
    .in_ready (in_tready),
    .cfg_ready(cfg_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: config, frame counters, line store, radix median select.
  rmwf_datapath #(
    .MAX_KERNEL(MAX_KERNEL),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_command(in_tuser),
    .in_pixel  (in_tdata),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_pixel (res_pix),
    .out_col   (res_col),
    .out_row   (res_row),
    .out_last  (out_tlast),
    .out_done  (out_tuser)
  );

  assign out_tdata = {1'b0, res_row, res_col, res_pix};

  // Input and config are only taken while idle.
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> cfg_ready) else $error("input ready outside idle");

  // An accepted transaction leaves idle, so ready is low in the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("ready right after accept");

  // The frame's final pixel always closes its run.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast) else $error("frame_done without tlast");

endmodule
`default_nettype wire

@@ hdl/rmwf_ctrl.sv @@
`default_nettype none
module rmwf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               cfg_valid,
  output logic                    in_ready,
  output logic                    cfg_ready,
  input  wire rmwf_pkg::dp_status_t st,
  output rmwf_pkg::ctrl_cmd_t     cmd
);
  import rmwf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_SETUP, S_ISSUE, S_DRAIN, S_DECIDE, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        if (in_valid && !cfg_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = st.has_res ? S_SETUP : S_IDLE;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (st.last_issue) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_DECIDE;
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = st.last_bit ? S_EMIT : S_ISSUE;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = st.last_x ? S_IDLE : S_SETUP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/rmwf_datapath.sv @@
`default_nettype none
module rmwf_datapath #(
  parameter int MAX_KERNEL = rmwf_pkg::DEF_MAX_KERNEL,
  parameter int MAX_WIDTH  = rmwf_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rmwf_pkg::ctrl_cmd_t           cmd,
  output rmwf_pkg::dp_status_t               st,
  input  wire logic                          cfg_we,
  input  wire logic [rmwf_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [rmwf_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          in_command,
  input  wire logic [rmwf_pkg::PIX_W-1:0]    in_pixel,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [rmwf_pkg::PIX_W-1:0]         out_pixel,
  output logic [rmwf_pkg::OCOL_W-1:0]        out_col,
  output logic [rmwf_pkg::OROW_W-1:0]        out_row,
  output logic                               out_last,
  output logic                               out_done
);
  import rmwf_pkg::*;

  localparam int SLOT_W = $clog2(MAX_KERNEL + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ADDR_W = SLOT_W + COL_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CNT_W  = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int UW     = CRD_W - 1;

  logic [KSIZE_W-1:0] ksize_r;
  logic [WIDTH_W-1:0] width_r;
  logic [HGT_W-1:0]   height_r;
  logic [UW-1:0]      col_cnt_r, row_cnt_r;
  logic               cmd_r;
  logic [PIX_W-1:0]   pix_r;

  logic [PIX_W-1:0]   mem [DEPTH];
  logic [PIX_W-1:0]   rd_data_r;
  logic               rd_v_r;

  logic signed [CRD_W-1:0] x_r, xe_r, y_r;
  logic [KEFF_W-1:0]  i_r, j_r;
  logic [3:0]         bit_r;
  logic [CHAN_W-1:0]  pref_r [NCHAN];
  logic [CNT_W-1:0]   rank_r [NCHAN];
  logic [CNT_W-1:0]   cnt_r  [NCHAN];

  logic [KEFF_W-1:0]  k_eff, fn, lo;
  logic [UW-1:0]      w_eff, h_eff, fn_u;
  logic [CNT_W-1:0]   half_n;

  always_comb begin
    if (ksize_r == '0) k_eff = KEFF_W'(1);
    else if (KEFF_W'(ksize_r) > KEFF_W'(MAX_KERNEL)) k_eff = KEFF_W'(MAX_KERNEL);
    else k_eff = KEFF_W'(ksize_r);
    if (width_r == '0) w_eff = UW'(1);
    else if (UW'(width_r) > UW'(MAX_WIDTH)) w_eff = UW'(MAX_WIDTH);
    else w_eff = UW'(width_r);
    if (height_r == '0) h_eff = UW'(1);
    else if (UW'(height_r) > UW'(HEIGHT_LIMIT)) h_eff = UW'(HEIGHT_LIMIT);
    else h_eff = UW'(height_r);
  end

  assign fn     = (k_eff - KEFF_W'(1)) >> 1;
  assign lo     = k_eff >> 1;
  assign fn_u   = UW'(fn);
  assign half_n = CNT_W'((2 * CNT_W)'(k_eff) * (2 * CNT_W)'(k_eff) >> 1);

  // Frame position of the item under evaluation.
  logic          wrap, store, ignore, last_col;
  logic [UW-1:0] cn, rn, c_adv, r_adv, r_inc;
  logic signed [CRD_W-1:0] yv, xs, xe;

  always_comb begin
    wrap     = (col_cnt_r >= w_eff) || (row_cnt_r >= h_eff + fn_u);
    cn       = wrap ? '0 : col_cnt_r;
    rn       = wrap ? '0 : row_cnt_r;
    yv       = $signed({1'b0, rn}) - $signed({1'b0, fn_u});
    store    = (rn < h_eff) && !cmd_r;
    ignore   = (rn < h_eff) && cmd_r;
    last_col = (cn == w_eff - UW'(1));
    xs       = (cn >= fn_u) ? $signed({1'b0, cn - fn_u}) : '0;
    xe       = last_col ? $signed({1'b0, w_eff - UW'(1)})
                        : $signed({1'b0, cn}) - $signed({1'b0, fn_u});
    r_inc    = rn + UW'(1);
    if (cn + UW'(1) >= w_eff) begin
      c_adv = '0;
      r_adv = (r_inc >= h_eff + fn_u) ? '0 : r_inc;
    end else begin
      c_adv = cn + UW'(1);
      r_adv = rn;
    end
  end

  // Window sample address, clamped to the frame edges.
  logic signed [CRD_W-1:0] wr_s, wc_s;
  logic [UW-1:0]           wr_u, wc_u;
  logic [ADDR_W-1:0]       rd_addr, wr_addr;

  always_comb begin
    wr_s = y_r - $signed({1'b0, UW'(lo)}) + $signed({1'b0, UW'(i_r)});
    wc_s = x_r - $signed({1'b0, UW'(lo)}) + $signed({1'b0, UW'(j_r)});
    if (wr_s < 0) wr_u = '0;
    else if (wr_s > $signed({1'b0, h_eff - UW'(1)})) wr_u = h_eff - UW'(1);
    else wr_u = UW'(wr_s);
    if (wc_s < 0) wc_u = '0;
    else if (wc_s > $signed({1'b0, w_eff - UW'(1)})) wc_u = w_eff - UW'(1);
    else wc_u = UW'(wc_s);
    rd_addr = {wr_u[SLOT_W-1:0], wc_u[COL_W-1:0]};
    wr_addr = {rn[SLOT_W-1:0], cn[COL_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && store) mem[wr_addr] <= pix_r;
    rd_data_r <= mem[rd_addr];
  end

  logic [CHAN_W-1:0] hi_mask;
  assign hi_mask = CHAN_W'(8'hFF << (bit_r + 4'd1));

  assign st.has_res    = !ignore && !yv[CRD_W-1] && (last_col || cn >= fn_u);
  assign st.last_issue = (i_r == k_eff - KEFF_W'(1)) && (j_r == k_eff - KEFF_W'(1));
  assign st.last_bit   = (bit_r == 4'd0);
  assign st.last_x     = (x_r == xe_r);
  assign st.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ksize_r   <= KSIZE_W'(3);
      width_r   <= WIDTH_W'(640);
      height_r  <= HGT_W'(480);
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      rd_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_v_r <= cmd.issue;
      if (cfg_we) begin
        case (cfg_index)
          REG_KERNEL: ksize_r  <= cfg_data[KSIZE_W-1:0];
          REG_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
          REG_HEIGHT: height_r <= cfg_data[HGT_W-1:0];
          default: ;
        endcase
        if (cfg_index == REG_KERNEL || cfg_index == REG_WIDTH ||
            cfg_index == REG_HEIGHT) begin
          col_cnt_r <= '0;
          row_cnt_r <= '0;
        end
      end
      if (cmd.eval && !ignore) begin
        col_cnt_r <= c_adv;
        row_cnt_r <= r_adv;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= in_command;
      pix_r <= in_pixel;
    end
    if (cmd.eval) begin
      x_r  <= xs;
      xe_r <= xe;
      y_r  <= yv;
    end
    if (cmd.setup) begin
      i_r   <= '0;
      j_r   <= '0;
      bit_r <= 4'd7;
      for (int c = 0; c < NCHAN; c++) begin
        pref_r[c] <= '0;
        rank_r[c] <= half_n;
        cnt_r[c]  <= '0;
      end
    end
    if (cmd.issue) begin
      if (j_r == k_eff - KEFF_W'(1)) begin
        j_r <= '0;
        i_r <= i_r + KEFF_W'(1);
      end else begin
        j_r <= j_r + KEFF_W'(1);
      end
    end
    // Count samples that share the decided prefix and have a zero here.
    if (rd_v_r) begin
      for (int c = 0; c < NCHAN; c++) begin
        if ((((rd_data_r[c*CHAN_W +: CHAN_W] ^ pref_r[c]) & hi_mask) == '0) &&
            !rd_data_r[c*CHAN_W + int'(bit_r)])
          cnt_r[c] <= cnt_r[c] + CNT_W'(1);
      end
    end
    if (cmd.decide) begin
      i_r   <= '0;
      j_r   <= '0;
      bit_r <= bit_r - 4'd1;
      for (int c = 0; c < NCHAN; c++) begin
        cnt_r[c] <= '0;
        if (rank_r[c] >= cnt_r[c]) begin
          pref_r[c][bit_r[2:0]] <= 1'b1;
          rank_r[c] <= rank_r[c] - cnt_r[c];
        end
      end
    end
    if (cmd.emit) begin
      out_pixel <= {pref_r[2], pref_r[1], pref_r[0]};
      out_col   <= OCOL_W'(x_r);
      out_row   <= OROW_W'(y_r);
      out_last  <= (x_r == xe_r);
      out_done  <= (x_r == $signed({1'b0, w_eff - UW'(1)})) &&
                   (y_r == $signed({1'b0, h_eff - UW'(1)}));
      x_r       <= x_r + CRD_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps
module tb;
  import rmwf_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_KERNEL * DEF_MAX_WIDTH;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [OCOL_W-1:0] column;
    logic [OROW_W-1:0] row;
    logic              run_end;
    logic              frame_end;
  } pixel_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [23:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // Shadow of the filter: registers, raster position and line store.
  logic [KSIZE_W-1:0] shadow_kernel;
  logic [WIDTH_W-1:0] shadow_width;
  logic [HGT_W-1:0]   shadow_height;
  int shadow_col;
  int shadow_row;
  logic [PIX_W-1:0] shadow_lines [STORE_DEPTH];

  pixel_result_t pending_medians[$];
  int error_count;
  int items_sent;

  rgb_median_window_filter_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Overall limit: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic int kernel_eff();
    if (shadow_kernel == 0) return 1;
    if (shadow_kernel > DEF_MAX_KERNEL) return DEF_MAX_KERNEL;
    return int'(shadow_kernel);
  endfunction

  function automatic int width_eff();
    if (shadow_width == 0) return 1;
    if (shadow_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return int'(shadow_width);
  endfunction

  function automatic int height_eff();
    if (shadow_height == 0) return 1;
    if (shadow_height > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return int'(shadow_height);
  endfunction

  // Rank-select the middle sample of each channel via per-value counts.
  task automatic window_medians(input int x, input int y, input int k, input int w,
                                input int h, output logic [7:0] med [3]);
    int counts [3][256];
    int half;
    int rr;
    int cc;
    int acc;
    logic [PIX_W-1:0] px;
    half = (k * k) / 2;
    foreach (counts[ch, v]) counts[ch][v] = 0;
    for (int i = 0; i < k; i++) begin
      rr = y - k / 2 + i;
      if (rr < 0) rr = 0;
      if (rr > h - 1) rr = h - 1;
      for (int j = 0; j < k; j++) begin
        cc = x - k / 2 + j;
        if (cc < 0) cc = 0;
        if (cc > w - 1) cc = w - 1;
        px = shadow_lines[(rr % DEF_MAX_KERNEL) * DEF_MAX_WIDTH + cc];
        counts[0][px[7:0]]++;
        counts[1][px[15:8]]++;
        counts[2][px[23:16]]++;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0;
      med[ch] = 8'hFF;
      for (int v = 0; v < 256; v++) begin
        acc += counts[ch][v];
        if (acc > half) begin
          med[ch] = v[7:0];
          break;
        end
      end
    end
  endtask

  // Advance the shadow by one accepted pixel and queue the medians it releases.
  task automatic predict_medians(input logic pad, input logic [23:0] rgb);
    int k;
    int w;
    int h;
    int fn;
    int c;
    int r;
    int y;
    int xs;
    int xe;
    logic [7:0] med [3];
    pixel_result_t res;
    k = kernel_eff();
    w = width_eff();
    h = height_eff();
    fn = (k - 1) / 2;
    c = shadow_col;
    r = shadow_row;
    if (c >= w || r >= h + fn) begin
      c = 0;
      r = 0;
    end
    y = r - fn;
    if (r < h) begin
      // Pad during real rows: dropped without any effect.
      if (pad) return;
      shadow_lines[(r % DEF_MAX_KERNEL) * DEF_MAX_WIDTH + c] = rgb;
    end
    if (y >= 0) begin
      xs = (c - fn < 0) ? 0 : c - fn;
      xe = (c == w - 1) ? w - 1 : c - fn;
      for (int x = xs; x <= xe; x++) begin
        window_medians(x, y, k, w, h, med);
        res.red = med[0];
        res.green = med[1];
        res.blue = med[2];
        res.column = x[OCOL_W-1:0];
        res.row = y[OROW_W-1:0];
        res.run_end = (x == xe);
        res.frame_end = (x == w - 1 && y == h - 1);
        pending_medians = {pending_medians, res};
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h + fn) r = 0;
    end
    shadow_col = c;
    shadow_row = r;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Check every result transaction against the oldest expectation.
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_medians.size() == 0) begin
        $display("[%0t] result with nothing expected", $realtime);
        error_count++;
      end else begin
        want = pending_medians.pop_front();
        if (out_tdata[7:0] !== want.red)
          report_mismatch("red", int'(out_tdata[7:0]), int'(want.red));
        if (out_tdata[15:8] !== want.green)
          report_mismatch("green", int'(out_tdata[15:8]), int'(want.green));
        if (out_tdata[23:16] !== want.blue)
          report_mismatch("blue", int'(out_tdata[23:16]), int'(want.blue));
        if (out_tdata[34:24] !== want.column)
          report_mismatch("column", int'(out_tdata[34:24]), int'(want.column));
        if (out_tdata[46:35] !== want.row)
          report_mismatch("row", int'(out_tdata[46:35]), int'(want.row));
        if (out_tdata[47] !== 1'b0) report_mismatch("spare bit", int'(out_tdata[47]), 0);
        if (out_tlast !== want.run_end)
          report_mismatch("tlast", int'(out_tlast), int'(want.run_end));
        if (out_tuser !== want.frame_end)
          report_mismatch("tuser", int'(out_tuser), int'(want.frame_end));
      end
    end
  end

  // Receiver backpressure: random runs of ready/stall, now and then a long ready stretch.
  int ready_run;
  initial begin
    out_tready = 1'b0;
    ready_run = 0;
    forever begin
      @(negedge clk);
      if (ready_run == 0) begin
        if ($urandom_range(0, 7) == 0) begin
          out_tready = 1'b1;
          ready_run = 40;
        end else begin
          out_tready = 1'($urandom_range(0, 1));
          ready_run = $urandom_range(1, 6);
        end
      end
      ready_run--;
    end
  end

  // Send one pixel transaction; hold it until accepted, then update the shadow.
  task automatic send_pixel(input logic pad, input logic [23:0] rgb);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = pad;
    in_tdata = rgb;
    do @(posedge clk); while (!in_tready);
    predict_medians(pad, rgb);
    items_sent++;
  endtask

  // Burst pacing: after a transaction, maybe drop valid for a random gap.
  task automatic maybe_gap();
    if ($urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  // Drop valid and hold until every expected result is in, then let the block settle.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    wait (pending_medians.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input int value);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KERNEL: shadow_kernel = value[KSIZE_W-1:0];
      REG_WIDTH:  shadow_width = value[WIDTH_W-1:0];
      REG_HEIGHT: shadow_height = value[HGT_W-1:0];
      default: ;
    endcase
    shadow_col = 0;
    shadow_row = 0;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_frame(input int k, input int w, input int h);
    write_reg(REG_KERNEL, k);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // Extreme channel values and alternating bit patterns on a single-pixel window.
  task automatic test_channel_extremes();
    set_frame(15, 4095, 8191);
    write_reg(REG_KERNEL, 1);
    send_pixel(1'b0, 24'h000000);
    send_pixel(1'b0, 24'hFFFFFF);
    send_pixel(1'b0, 24'hAA55AA);
    send_pixel(1'b0, 24'h55AA55);
    // Pad while real rows are expected: dropped.
    send_pixel(1'b1, 24'h123456);
    send_pixel(1'b0, 24'h0F81F0);
  endtask

  // Zero registers act as one; a one-pixel frame completes with each pixel.
  task automatic test_zero_registers();
    set_frame(0, 0, 0);
    send_pixel(1'b0, 24'h7F8001);
    send_pixel(1'b0, 24'h01807F);
  endtask

  // Largest kernel on a tiny frame: long drain, clamping on every side.
  task automatic test_largest_kernel();
    set_frame(15, 2, 1);
    write_reg(REG_HEIGHT, 4096);
    write_reg(REG_HEIGHT, 1);
    send_pixel(1'b0, 24'h10E0F0);
    send_pixel(1'b0, 24'hF02010);
    // Drain rows: pads and ignored pixels both count as pads.
    for (int i = 0; i < 14; i++) send_pixel(i[0], 24'hFFFFFF);
  endtask

  // Random frames, mostly small kernels, with noise pads and aborted frames.
  task automatic test_random_frames();
    int k;
    int w;
    int h;
    int fn;
    int total;
    bit paused;
    paused = 1'b0;
    while (items_sent < 450) begin
      k = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
      w = $urandom_range(1, 10);
      h = $urandom_range(1, 6);
      fn = (k - 1) / 2;
      set_frame(k, w, h);
      total = w * (h + fn);
      for (int i = 0; i < total; i++) begin
        if (i < w * h && $urandom_range(0, 9) == 0) send_pixel(1'b1, 24'($urandom));
        send_pixel((i >= w * h) ? 1'($urandom_range(0, 1)) : 1'b0, 24'($urandom));
        maybe_gap();
        // Hold off once mid-frame until all results are back.
        if (!paused && items_sent > 200) begin
          paused = 1'b1;
          drain_results();
        end
        // Occasionally abandon the frame; the next write restarts it.
        if ($urandom_range(0, 149) == 0) break;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_KERNEL;
    cfg_data = '0;
    shadow_kernel = 3;
    shadow_width = 640;
    shadow_height = 480;
    shadow_col = 0;
    shadow_row = 0;
    error_count = 0;
    items_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_channel_extremes();
    test_zero_registers();
    test_largest_kernel();
    test_random_frames();

    @(negedge clk);
    in_tvalid = 1'b0;
    wait (pending_medians.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
